FILE: hdl/modular_exponentiation_macros.svh
// Assertion macros for the modular exponentiation block.
// Used by modules that write concurrent checks; expects clk and rst_n in scope.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: hdl/mexp_pkg.sv
// Shared types for the modular exponentiation block.
// Datapath operation codes and the status bundle; no dependencies.
package mexp_pkg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_ACC,
        OP_MUL_SQ,
        OP_REDUCE,
        OP_STORE_BASE,
        OP_STORE_ACC,
        OP_STORE_SQ,
        OP_DONE
    } dp_op_t;

    typedef struct packed {
        logic exp_bit;
        logic red_last;
    } dp_status_t;

endpackage

FILE: hdl/mexp_dpath.sv
// Datapath of the modular exponentiation block: operand registers, multiplier,
// bit-serial restoring reducer and result register. Depends on mexp_pkg.
module mexp_dpath
    import mexp_pkg::*;
#(
    parameter int WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [WIDTH-1:0] base_value,
    input  logic [WIDTH-1:0] exponent,
    input  logic             modulus_we,
    input  logic [WIDTH-1:0] modulus_wdata,
    input  dp_op_t           op,
    output dp_status_t       status,
    output logic             done,
    output logic [WIDTH-1:0] power_result
);

    localparam int PW = 2 * WIDTH;
    localparam int CW = $clog2(PW);
    localparam logic [CW-1:0] CNT_LAST = CW'(PW - 1);

    logic [WIDTH-1:0] modulus_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] base_reg;
    logic [WIDTH-1:0] exp_reg;
    logic [PW-1:0]    prod_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic             done_reg;
    logic [WIDTH-1:0] result_reg;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   mod_ext;
    logic [WIDTH:0]   diff;
    logic [WIDTH-1:0] rem_next;
    logic [PW-1:0]    product;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign trial    = {rem_reg, prod_reg[PW-1]};
    assign mod_ext  = {1'b0, modulus_reg};
    assign diff     = trial - mod_ext;
    assign rem_next = (trial >= mod_ext) ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    assign product  = PW'(acc_reg) * PW'(base_reg);
    assign cnt_next = (cnt_reg == CNT_LAST) ? '0 : cnt_reg + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= WIDTH'(23);
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (modulus_we)
            begin
                modulus_reg <= modulus_wdata;
            end
            done_reg <= (op == OP_DONE);
            case (op) inside
                OP_LOAD, OP_MUL_ACC, OP_MUL_SQ: cnt_reg <= '0;
                OP_REDUCE:                      cnt_reg <= cnt_next;
                default:                        cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                prod_reg <= {{WIDTH{1'b0}}, base_value};
                rem_reg  <= '0;
                exp_reg  <= exponent;
                acc_reg  <= WIDTH'(1);
            end
            OP_MUL_ACC:
            begin
                prod_reg <= product;
                rem_reg  <= '0;
            end
            OP_MUL_SQ:
            begin
                prod_reg <= PW'(base_reg) * PW'(base_reg);
                rem_reg  <= '0;
            end
            OP_REDUCE:
            begin
                prod_reg <= {prod_reg[PW-2:0], 1'b0};
                rem_reg  <= rem_next;
            end
            OP_STORE_BASE:
            begin
                base_reg <= rem_reg;
            end
            OP_STORE_ACC:
            begin
                acc_reg <= rem_reg;
            end
            OP_STORE_SQ:
            begin
                base_reg <= rem_reg;
                exp_reg  <= {1'b0, exp_reg[WIDTH-1:1]};
            end
            OP_DONE:
            begin
                // every residue is zero for a modulus below two
                result_reg <= (modulus_reg < WIDTH'(2)) ? '0 : acc_reg;
            end
            default:
            begin
            end
        endcase
    end

    // The count only reaches its last value on the final step of a reduction.
    assign status.exp_bit  = exp_reg[0];
    assign status.red_last = (cnt_reg == CNT_LAST);
    assign done            = done_reg;
    assign power_result    = result_reg;

endmodule

FILE: hdl/mexp_ctrl.sv
// Controller of the modular exponentiation block: sequences base reduction,
// per-bit multiply and square. Depends on mexp_pkg and the assertion macros.
`include "modular_exponentiation_macros.svh"

module mexp_ctrl
    import mexp_pkg::*;
#(
    parameter int WIDTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_op_t     op,
    output logic       busy
);

    localparam int BW = $clog2(WIDTH);
    localparam logic [BW-1:0] BIT_LAST = BW'(WIDTH - 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_RBASE  = 10'b00_0000_0010,
        S_BSTORE = 10'b00_0000_0100,
        S_BIT    = 10'b00_0000_1000,
        S_MRED   = 10'b00_0001_0000,
        S_MSTORE = 10'b00_0010_0000,
        S_SQ     = 10'b00_0100_0000,
        S_SRED   = 10'b00_1000_0000,
        S_SSTORE = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [BW-1:0]   bit_cnt_reg;
    logic [BW-1:0]   bit_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        op           = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op           = OP_LOAD;
                    bit_cnt_next = '0;
                    state_next   = S_RBASE;
                end
            end
            S_RBASE:
            begin
                op = OP_REDUCE;
                if (status.red_last)
                begin
                    state_next = S_BSTORE;
                end
            end
            S_BSTORE:
            begin
                op         = OP_STORE_BASE;
                state_next = S_BIT;
            end
            S_BIT:
            begin
                // skip the multiply when the exponent bit is clear
                if (status.exp_bit)
                begin
                    op         = OP_MUL_ACC;
                    state_next = S_MRED;
                end
                else
                begin
                    op         = OP_MUL_SQ;
                    state_next = S_SRED;
                end
            end
            S_MRED:
            begin
                op = OP_REDUCE;
                if (status.red_last)
                begin
                    state_next = S_MSTORE;
                end
            end
            S_MSTORE:
            begin
                op         = OP_STORE_ACC;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                op         = OP_MUL_SQ;
                state_next = S_SRED;
            end
            S_SRED:
            begin
                op = OP_REDUCE;
                if (status.red_last)
                begin
                    state_next = S_SSTORE;
                end
            end
            S_SSTORE:
            begin
                op = OP_STORE_SQ;
                if (bit_cnt_reg == BIT_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + BW'(1);
                    state_next   = S_BIT;
                end
            end
            S_DONE:
            begin
                op         = OP_DONE;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `MEXP_ASSERT_NEXT(a_start_reduce, start && !busy, state_reg == S_RBASE)
    `MEXP_ASSERT_NEXT(a_done_idle, state_reg == S_DONE, state_reg == S_IDLE)
    `MEXP_ASSERT_NOW(a_red_last, status.red_last,
        state_reg == S_RBASE || state_reg == S_MRED || state_reg == S_SRED)
    `MEXP_ASSERT_NEXT(a_last_bit, state_reg == S_SSTORE && bit_cnt_reg == BIT_LAST,
        state_reg == S_DONE)

endmodule

FILE: hdl/modular_exponentiation.sv
// Modular exponentiation: power_result = base_value ** exponent mod modulus,
// right-to-left square-and-multiply. A transaction is accepted when start is high
// and busy is low; the result appears on power_result for exactly one cycle with
// done high and cannot be stalled, so the receiver must take it then. A new start
// is taken in the same cycle as that strobe. The time from acceptance to done
// grows with the number of set exponent bits, as each adds a multiply and its
// reduction; it is set by the bit-serial reducer, which reduces each modular
// product one bit at a time. Write modulus only while busy is low; a modulus
// below two gives a result of zero.
// Depends on mexp_pkg, mexp_ctrl and mexp_dpath.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] base_value,
    input  logic [WIDTH-1:0] exponent,
    input  logic             modulus_we,
    input  logic [WIDTH-1:0] modulus_wdata,
    output logic             done,
    output logic [WIDTH-1:0] power_result
);

    dp_op_t     op;
    dp_status_t status;

    mexp_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .op     (op),
        .busy   (busy)
    );

    mexp_dpath #(
        .WIDTH (WIDTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .base_value    (base_value),
        .exponent      (exponent),
        .modulus_we    (modulus_we),
        .modulus_wdata (modulus_wdata),
        .op            (op),
        .status        (status),
        .done          (done),
        .power_result  (power_result)
    );

endmodule
